FILE: design/lorenz_heun_stepper_unit_defines.svh
// Assertion macros of the checker file of the Lorenz stepper
`ifndef LORENZ_HEUN_STEPPER_UNIT_DEFINES_SVH
`define LORENZ_HEUN_STEPPER_UNIT_DEFINES_SVH

// Clocked property, off while reset is asserted
`define LHS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked same-cycle implication, off while reset is asserted
`define LHS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/lhs_pkg.sv
// Shared types, codes, reset values and the Heun micro-program of the Lorenz stepper
package lhs_pkg;

  // input commands
  localparam logic [1:0] IN_STEP  = 2'd0;
  localparam logic [1:0] IN_LOAD  = 2'd1;
  localparam logic [1:0] IN_RESET = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_R  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_C  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_Z  = 3'd6;

  localparam int DT_W = 25;

  localparam logic [31:0]     RST_COEF_A = 32'd167772160;
  localparam logic [31:0]     RST_COEF_R = 32'd469762048;
  localparam logic [31:0]     RST_COEF_C = 32'd44795167;
  localparam logic [DT_W-1:0] RST_DT     = 25'd167772;
  localparam logic [31:0]     RST_INIT   = 32'd1677722;

  // operand / destination codes of the micro-program
  typedef enum logic [3:0] {
    OPD_X, OPD_Y, OPD_Z,
    OPD_T0, OPD_T1, OPD_T2, OPD_T3, OPD_T4, OPD_T5, OPD_T6,
    OPD_A, OPD_R, OPD_C, OPD_DT, OPD_DT2
  } opd_e;

  typedef enum logic [1:0] {
    ALU_ADD, ALU_SUB, ALU_MUL
  } uop_kind_e;

  typedef struct packed {
    uop_kind_e kind;
    opd_e      src_a;
    opd_e      src_b;
    opd_e      dst;
  } uop_t;

  // datapath commands from the sequencer
  typedef enum logic [3:0] {
    DP_IDLE, DP_ALU, DP_MUL_LOAD, DP_MUL_LO, DP_MUL_HI, DP_MUL_FIN,
    DP_LOAD_IN, DP_LOAD_INIT, DP_SNAP, DP_PUBLISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    uop_t   uop;
  } dp_cmd_t;

  localparam int UOP_COUNT = 31;
  localparam int UOP_IDX_W = $clog2(UOP_COUNT);

  function automatic uop_t mk_uop(uop_kind_e k, opd_e a, opd_e b, opd_e d);
    uop_t u;
    u.kind  = k;
    u.src_a = a;
    u.src_b = b;
    u.dst   = d;
    return u;
  endfunction

  // f at the point into T1..T3, predictor into T4..T6, f+g into T1..T3, then corrector
  function automatic uop_t heun_uop(logic [UOP_IDX_W-1:0] idx);
    uop_t u;
    case (idx)
      5'd0:    u = mk_uop(ALU_SUB, OPD_Y,   OPD_X,  OPD_T0);
      5'd1:    u = mk_uop(ALU_MUL, OPD_A,   OPD_T0, OPD_T1);
      5'd2:    u = mk_uop(ALU_SUB, OPD_R,   OPD_Z,  OPD_T0);
      5'd3:    u = mk_uop(ALU_MUL, OPD_X,   OPD_T0, OPD_T2);
      5'd4:    u = mk_uop(ALU_SUB, OPD_T2,  OPD_Y,  OPD_T2);
      5'd5:    u = mk_uop(ALU_MUL, OPD_X,   OPD_Y,  OPD_T0);
      5'd6:    u = mk_uop(ALU_MUL, OPD_Z,   OPD_C,  OPD_T3);
      5'd7:    u = mk_uop(ALU_SUB, OPD_T0,  OPD_T3, OPD_T3);
      5'd8:    u = mk_uop(ALU_MUL, OPD_DT,  OPD_T1, OPD_T0);
      5'd9:    u = mk_uop(ALU_ADD, OPD_X,   OPD_T0, OPD_T4);
      5'd10:   u = mk_uop(ALU_MUL, OPD_DT,  OPD_T2, OPD_T0);
      5'd11:   u = mk_uop(ALU_ADD, OPD_Y,   OPD_T0, OPD_T5);
      5'd12:   u = mk_uop(ALU_MUL, OPD_DT,  OPD_T3, OPD_T0);
      5'd13:   u = mk_uop(ALU_ADD, OPD_Z,   OPD_T0, OPD_T6);
      5'd14:   u = mk_uop(ALU_SUB, OPD_T5,  OPD_T4, OPD_T0);
      5'd15:   u = mk_uop(ALU_MUL, OPD_A,   OPD_T0, OPD_T0);
      5'd16:   u = mk_uop(ALU_ADD, OPD_T1,  OPD_T0, OPD_T1);
      5'd17:   u = mk_uop(ALU_SUB, OPD_R,   OPD_T6, OPD_T0);
      5'd18:   u = mk_uop(ALU_MUL, OPD_T4,  OPD_T0, OPD_T0);
      5'd19:   u = mk_uop(ALU_SUB, OPD_T0,  OPD_T5, OPD_T0);
      5'd20:   u = mk_uop(ALU_ADD, OPD_T2,  OPD_T0, OPD_T2);
      5'd21:   u = mk_uop(ALU_MUL, OPD_T4,  OPD_T5, OPD_T0);
      5'd22:   u = mk_uop(ALU_MUL, OPD_T6,  OPD_C,  OPD_T4);
      5'd23:   u = mk_uop(ALU_SUB, OPD_T0,  OPD_T4, OPD_T0);
      5'd24:   u = mk_uop(ALU_ADD, OPD_T3,  OPD_T0, OPD_T3);
      5'd25:   u = mk_uop(ALU_MUL, OPD_DT2, OPD_T1, OPD_T0);
      5'd26:   u = mk_uop(ALU_ADD, OPD_X,   OPD_T0, OPD_X);
      5'd27:   u = mk_uop(ALU_MUL, OPD_DT2, OPD_T2, OPD_T0);
      5'd28:   u = mk_uop(ALU_ADD, OPD_Y,   OPD_T0, OPD_Y);
      5'd29:   u = mk_uop(ALU_MUL, OPD_DT2, OPD_T3, OPD_T0);
      5'd30:   u = mk_uop(ALU_ADD, OPD_Z,   OPD_T0, OPD_Z);
      default: u = mk_uop(ALU_ADD, OPD_T0,  OPD_T0, OPD_T0);
    endcase
    return u;
  endfunction

endpackage

FILE: design/lorenz_heun_stepper_unit.sv
// Top level of the Lorenz stepper: sequencer, datapath and configuration port
// Holds a Lorenz point in signed fixed point and, on a step command, returns the
// point as it stood and moves it on by one Heun step (saturating arithmetic,
// with a flag when anything clipped). A step keeps in_stall_o high until its result
// is published, also while an earlier result still waits. The micro-program runs
// 17 add/subtract ops and 14 products; each product goes through operand load,
// two partial-product passes, truncate and saturate on the single shared multiplier.
// The result sits in an output register, so the next item is taken while it waits.
// Load and reset commands act at their transfer and the next item is taken the
// cycle after. Configuration writes are always ready and are meant for an idle block.
module lorenz_heun_stepper_unit #(
  parameter int FRAC_BITS   = 24,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic signed [31:0]            x_in_i,
  input  logic signed [31:0]            y_in_i,
  input  logic signed [31:0]            z_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            x_out_o,
  output logic signed [31:0]            y_out_o,
  output logic signed [31:0]            z_out_o,
  output logic                          saturated_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lhs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  lhs_pkg::dp_cmd_t dp_cmd;
  logic             cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  lhs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .dp_cmd_o    (dp_cmd)
  );

  lhs_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .dp_cmd_i    (dp_cmd),
    .x_in_i      (x_in_i),
    .y_in_i      (y_in_i),
    .z_in_i      (z_in_i),
    .x_out_o     (x_out_o),
    .y_out_o     (y_out_o),
    .z_out_o     (z_out_o),
    .saturated_o (saturated_o)
  );

endmodule

FILE: design/lhs_ctrl.sv
// Sequencer of the Lorenz stepper: handshakes and micro-program walk
module lhs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           cmd_i,
  output logic                 in_stall_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output lhs_pkg::dp_cmd_t     dp_cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_MLO   = 3'd2;
  localparam logic [2:0] S_MHI   = 3'd3;
  localparam logic [2:0] S_MFIN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [lhs_pkg::UOP_IDX_W-1:0] UopLast =
    lhs_pkg::UOP_IDX_W'(lhs_pkg::UOP_COUNT - 1);

  logic [2:0]                      state_q, state_d;
  logic [lhs_pkg::UOP_IDX_W-1:0]   idx_q, idx_d;
  logic                            out_valid_q, out_valid_d;
  logic                            in_xfer;
  lhs_pkg::uop_t                   uop;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign uop         = lhs_pkg::heun_uop(idx_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    dp_cmd_o.op  = lhs_pkg::DP_IDLE;
    dp_cmd_o.uop = uop;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (cmd_i)
            lhs_pkg::IN_STEP: begin
              dp_cmd_o.op = lhs_pkg::DP_SNAP;
              idx_d       = '0;
              state_d     = S_ISSUE;
            end
            lhs_pkg::IN_LOAD:  dp_cmd_o.op = lhs_pkg::DP_LOAD_IN;
            lhs_pkg::IN_RESET: dp_cmd_o.op = lhs_pkg::DP_LOAD_INIT;
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        if (uop.kind == lhs_pkg::ALU_MUL) begin
          dp_cmd_o.op = lhs_pkg::DP_MUL_LOAD;
          state_d     = S_MLO;
        end else begin
          dp_cmd_o.op = lhs_pkg::DP_ALU;
          if (idx_q == UopLast) begin
            state_d = S_DONE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_MLO: begin
        dp_cmd_o.op = lhs_pkg::DP_MUL_LO;
        state_d     = S_MHI;
      end
      S_MHI: begin
        dp_cmd_o.op = lhs_pkg::DP_MUL_HI;
        state_d     = S_MFIN;
      end
      S_MFIN: begin
        dp_cmd_o.op = lhs_pkg::DP_MUL_FIN;
        if (idx_q == UopLast) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_ISSUE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          dp_cmd_o.op = lhs_pkg::DP_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: design/lhs_datapath.sv
// Datapath of the Lorenz stepper: registers, saturating adder and shared multiplier
module lhs_datapath #(
  parameter int FRAC_BITS   = 24,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lhs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  input  lhs_pkg::dp_cmd_t                  dp_cmd_i,
  input  logic signed [31:0]                x_in_i,
  input  logic signed [31:0]                y_in_i,
  input  logic signed [31:0]                z_in_i,
  output logic signed [31:0]                x_out_o,
  output logic signed [31:0]                y_out_o,
  output logic signed [31:0]                z_out_o,
  output logic                              saturated_o
);

  localparam int Vw   = VALUE_WIDTH;
  // dt is an unsigned 25-bit field, so the multiplier operand never drops below 26 bits
  localparam int MulW = (Vw > lhs_pkg::DT_W) ? Vw : lhs_pkg::DT_W + 1;
  localparam int LoW  = (MulW + 1) / 2;
  localparam int PrW  = MulW + LoW;
  localparam int AccW = 2 * MulW;

  localparam logic signed [Vw-1:0] VMax = {1'b0, {(Vw-1){1'b1}}};
  localparam logic signed [Vw-1:0] VMin = {1'b1, {(Vw-1){1'b0}}};
  localparam logic [AccW:0]        VMag = (AccW+1)'(1) << (Vw - 1);
  localparam logic signed [63:0]   OutMax = 64'sd2147483647;
  localparam logic signed [63:0]   OutMin = -64'sd2147483648;

  function automatic logic signed [Vw-1:0] clamp_in(logic signed [31:0] v);
    logic signed [63:0] w;
    logic signed [Vw-1:0] r;
    w = 64'(v);
    if (w > 64'(VMax)) begin
      r = VMax;
    end else if (w < 64'(VMin)) begin
      r = VMin;
    end else begin
      r = w[Vw-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_out(logic signed [Vw-1:0] v);
    logic signed [63:0] w;
    logic signed [31:0] r;
    w = 64'(v);
    if (w > OutMax) begin
      r = OutMax[31:0];
    end else if (w < OutMin) begin
      r = OutMin[31:0];
    end else begin
      r = w[31:0];
    end
    return r;
  endfunction

  logic [31:0]                coef_a_q, coef_r_q, coef_c_q;
  logic [31:0]                init_x_q, init_y_q, init_z_q;
  logic [lhs_pkg::DT_W-1:0]   dt_q;

  logic signed [Vw-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic signed [Vw-1:0] t0_q, t1_q, t2_q, t3_q, t4_q, t5_q, t6_q;
  logic signed [31:0]   snap_x_q, snap_y_q, snap_z_q;
  logic signed [31:0]   x_out_q, y_out_q, z_out_q;
  logic                 sat_q, sat_out_q;

  logic [MulW-1:0]      mag_a_q, mag_b_q;
  logic                 neg_q;
  logic [AccW-1:0]      acc_q;

  logic signed [Vw-1:0]   coef_a, coef_r, coef_c;
  logic signed [MulW-1:0] opa, opb;
  logic signed [Vw:0]     sum;
  logic signed [Vw-1:0]   alu_res, mul_res, wr_data;
  logic                   alu_ovf, mul_ovf, wr_en, wr_ovf;
  logic [LoW-1:0]         mul_b;
  logic [PrW-1:0]         prod;
  logic [AccW:0]          mx;
  logic [Vw-1:0]          mlow;
  lhs_pkg::uop_t          uop;

  assign uop    = dp_cmd_i.uop;
  assign coef_a = clamp_in(coef_a_q);
  assign coef_r = clamp_in(coef_r_q);
  assign coef_c = clamp_in(coef_c_q);

  function automatic logic signed [MulW-1:0] opd_read(lhs_pkg::opd_e sel);
    logic signed [MulW-1:0] r;
    case (sel)
      lhs_pkg::OPD_X:   r = MulW'(pos_x_q);
      lhs_pkg::OPD_Y:   r = MulW'(pos_y_q);
      lhs_pkg::OPD_Z:   r = MulW'(pos_z_q);
      lhs_pkg::OPD_T0:  r = MulW'(t0_q);
      lhs_pkg::OPD_T1:  r = MulW'(t1_q);
      lhs_pkg::OPD_T2:  r = MulW'(t2_q);
      lhs_pkg::OPD_T3:  r = MulW'(t3_q);
      lhs_pkg::OPD_T4:  r = MulW'(t4_q);
      lhs_pkg::OPD_T5:  r = MulW'(t5_q);
      lhs_pkg::OPD_T6:  r = MulW'(t6_q);
      lhs_pkg::OPD_A:   r = MulW'(coef_a);
      lhs_pkg::OPD_R:   r = MulW'(coef_r);
      lhs_pkg::OPD_C:   r = MulW'(coef_c);
      lhs_pkg::OPD_DT:  r = MulW'($signed({1'b0, dt_q}));
      lhs_pkg::OPD_DT2: r = MulW'($signed({2'b00, dt_q[lhs_pkg::DT_W-1:1]}));
      default:          r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    opa = opd_read(uop.src_a);
    opb = opd_read(uop.src_b);
  end

  // saturating add / subtract
  always_comb begin
    if (uop.kind == lhs_pkg::ALU_SUB) begin
      sum = {opa[Vw-1], opa[Vw-1:0]} - {opb[Vw-1], opb[Vw-1:0]};
    end else begin
      sum = {opa[Vw-1], opa[Vw-1:0]} + {opb[Vw-1], opb[Vw-1:0]};
    end
    alu_ovf = sum[Vw] ^ sum[Vw-1];
    if (alu_ovf) begin
      alu_res = sum[Vw] ? VMin : VMax;
    end else begin
      alu_res = sum[Vw-1:0];
    end
  end

  // magnitude multiply in two passes over the halves of operand b
  assign mul_b = (dp_cmd_i.op == lhs_pkg::DP_MUL_HI) ? LoW'(mag_b_q[MulW-1:LoW])
                                                     : mag_b_q[LoW-1:0];
  assign prod  = PrW'(mag_a_q) * PrW'(mul_b);

  // truncate toward zero, then saturate
  always_comb begin
    mx   = (AccW+1)'(acc_q >> FRAC_BITS);
    mlow = mx[Vw-1:0];
    if (neg_q) begin
      mul_ovf = (mx > VMag);
      mul_res = mul_ovf ? VMin : $signed(~mlow + Vw'(1));
    end else begin
      mul_ovf = (mx >= VMag);
      mul_res = mul_ovf ? VMax : $signed(mlow);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = alu_res;
    wr_ovf  = alu_ovf;
    case (dp_cmd_i.op)
      lhs_pkg::DP_ALU: wr_en = 1'b1;
      lhs_pkg::DP_MUL_FIN: begin
        wr_en   = 1'b1;
        wr_data = mul_res;
        wr_ovf  = mul_ovf;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= lhs_pkg::RST_COEF_A;
      coef_r_q <= lhs_pkg::RST_COEF_R;
      coef_c_q <= lhs_pkg::RST_COEF_C;
      dt_q     <= lhs_pkg::RST_DT;
      init_x_q <= lhs_pkg::RST_INIT;
      init_y_q <= lhs_pkg::RST_INIT;
      init_z_q <= lhs_pkg::RST_INIT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lhs_pkg::CFG_COEF_A:  coef_a_q <= cfg_data_i;
        lhs_pkg::CFG_COEF_R:  coef_r_q <= cfg_data_i;
        lhs_pkg::CFG_COEF_C:  coef_c_q <= cfg_data_i;
        lhs_pkg::CFG_STEP_DT: dt_q     <= cfg_data_i[lhs_pkg::DT_W-1:0];
        lhs_pkg::CFG_INIT_X:  init_x_q <= cfg_data_i;
        lhs_pkg::CFG_INIT_Y:  init_y_q <= cfg_data_i;
        lhs_pkg::CFG_INIT_Z:  init_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= clamp_in(lhs_pkg::RST_INIT);
      pos_y_q <= clamp_in(lhs_pkg::RST_INIT);
      pos_z_q <= clamp_in(lhs_pkg::RST_INIT);
    end else begin
      case (dp_cmd_i.op)
        lhs_pkg::DP_LOAD_IN: begin
          pos_x_q <= clamp_in(x_in_i);
          pos_y_q <= clamp_in(y_in_i);
          pos_z_q <= clamp_in(z_in_i);
        end
        lhs_pkg::DP_LOAD_INIT: begin
          pos_x_q <= clamp_in(init_x_q);
          pos_y_q <= clamp_in(init_y_q);
          pos_z_q <= clamp_in(init_z_q);
        end
        default: begin
          if (wr_en) begin
            case (uop.dst)
              lhs_pkg::OPD_X: pos_x_q <= wr_data;
              lhs_pkg::OPD_Y: pos_y_q <= wr_data;
              lhs_pkg::OPD_Z: pos_z_q <= wr_data;
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (uop.dst)
        lhs_pkg::OPD_T0: t0_q <= wr_data;
        lhs_pkg::OPD_T1: t1_q <= wr_data;
        lhs_pkg::OPD_T2: t2_q <= wr_data;
        lhs_pkg::OPD_T3: t3_q <= wr_data;
        lhs_pkg::OPD_T4: t4_q <= wr_data;
        lhs_pkg::OPD_T5: t5_q <= wr_data;
        lhs_pkg::OPD_T6: t6_q <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (dp_cmd_i.op)
      lhs_pkg::DP_MUL_LOAD: begin
        mag_a_q <= opa[MulW-1] ? $unsigned(-opa) : $unsigned(opa);
        mag_b_q <= opb[MulW-1] ? $unsigned(-opb) : $unsigned(opb);
        neg_q   <= opa[MulW-1] ^ opb[MulW-1];
      end
      lhs_pkg::DP_MUL_LO: acc_q <= AccW'(prod);
      lhs_pkg::DP_MUL_HI: acc_q <= acc_q + (AccW'(prod) << LoW);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (dp_cmd_i.op)
      lhs_pkg::DP_SNAP: begin
        snap_x_q <= clamp_out(pos_x_q);
        snap_y_q <= clamp_out(pos_y_q);
        snap_z_q <= clamp_out(pos_z_q);
        sat_q    <= 1'b0;
      end
      lhs_pkg::DP_PUBLISH: begin
        x_out_q   <= snap_x_q;
        y_out_q   <= snap_y_q;
        z_out_q   <= snap_z_q;
        sat_out_q <= sat_q;
      end
      default: begin
        if (wr_en && wr_ovf) begin
          sat_q <= 1'b1;
        end
      end
    endcase
  end

  assign x_out_o     = x_out_q;
  assign y_out_o     = y_out_q;
  assign z_out_o     = z_out_q;
  assign saturated_o = sat_out_q;

endmodule

FILE: design/lhs_checker.sv
// Port-level checks of the Lorenz stepper, bound to its top level
`include "lorenz_heun_stepper_unit_defines.svh"

module lhs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [1:0]                    cmd_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [31:0]            x_out_o,
  input logic signed [31:0]            y_out_o,
  input logic signed [31:0]            z_out_o,
  input logic                          saturated_o
);

  logic        in_xfer, step_xfer, other_xfer, out_wait;
  logic [96:0] out_pay;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign step_xfer  = in_xfer && (cmd_i == lhs_pkg::IN_STEP);
  assign other_xfer = in_xfer && (cmd_i != lhs_pkg::IN_STEP);
  assign out_wait   = out_valid_o && out_stall_i;
  assign out_pay    = {x_out_o, y_out_o, z_out_o, saturated_o};

  `LHS_ASSERT_CLK(a_out_hold, out_wait |=> out_valid_o && $stable(out_pay), "held result moved")

  `LHS_ASSERT_CLK(a_step_busy, step_xfer |=> in_stall_o, "step left the block free")

  `LHS_ASSERT_CLK(a_load_free, other_xfer |=> !in_stall_o, "non-step transfer left it busy")

  `LHS_ASSERT_IMPLIES(a_rise_busy, $rose(out_valid_o), $past(in_stall_o), "result outside a step")

endmodule

bind lorenz_heun_stepper_unit lhs_checker u_lhs_checker (.*);

FILE: test/lorenz_heun_stepper_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Lorenz Heun stepper: predicts every step result and checks it
module lorenz_heun_stepper_unit_tb;

  localparam logic [1:0] IN_UNUSED = 2'd3;
  localparam int FRAC = 24;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint unsigned VMAG = 64'h8000_0000;
  localparam int SETTLE = 100;
  localparam int QUIET_LIMIT = 3000;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] x, y, z;
  } lorenz_cmd_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               sat;
  } lorenz_sample_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    cmd_i = lhs_pkg::IN_STEP;
  logic signed [31:0]            x_in_i = '0;
  logic signed [31:0]            y_in_i = '0;
  logic signed [31:0]            z_in_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [31:0]            x_out_o, y_out_o, z_out_o;
  logic                          saturated_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [lhs_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]                   cfg_data_i = '0;

  // shadow configuration and point
  logic signed [31:0] k_a = lhs_pkg::RST_COEF_A;
  logic signed [31:0] k_r = lhs_pkg::RST_COEF_R;
  logic signed [31:0] k_c = lhs_pkg::RST_COEF_C;
  logic [lhs_pkg::DT_W-1:0] k_dt = lhs_pkg::RST_DT;
  logic signed [31:0] seed_x = lhs_pkg::RST_INIT, seed_y = lhs_pkg::RST_INIT;
  logic signed [31:0] seed_z = lhs_pkg::RST_INIT;
  logic signed [31:0] pt_x = lhs_pkg::RST_INIT, pt_y = lhs_pkg::RST_INIT;
  logic signed [31:0] pt_z = lhs_pkg::RST_INIT;
  bit                 clip_seen;

  lorenz_cmd_t    cmd_queue[$];
  lorenz_sample_t sample_queue[$];
  lorenz_cmd_t    drv_item;
  lorenz_sample_t drv_sample, mon_sample;

  int  idle_left, stall_left, quiet_cycles;
  bit  calm_in, calm_out;
  int  n_steps, n_loads, n_resets, n_ignored, n_clipped, n_settings, n_checked, n_errors;

  lorenz_heun_stepper_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .x_in_i      (x_in_i),
    .y_in_i      (y_in_i),
    .z_in_i      (z_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .x_out_o     (x_out_o),
    .y_out_o     (y_out_o),
    .z_out_o     (z_out_o),
    .saturated_o (saturated_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // saturating fixed-point arithmetic
  function automatic longint clip(longint v);
    if (v > VMAX) begin
      clip_seen = 1'b1;
      return VMAX;
    end
    if (v < VMIN) begin
      clip_seen = 1'b1;
      return VMIN;
    end
    return v;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    return clip(a - b);
  endfunction

  // product truncated toward zero
  function automatic longint mul_sat(longint a, longint b);
    bit neg;
    longint unsigned ma, mb, m;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma * mb) >> FRAC;
    if (neg) begin
      if (m > VMAG) begin
        clip_seen = 1'b1;
        return VMIN;
      end
      return -longint'(m);
    end
    if (m > VMAG - 1) begin
      clip_seen = 1'b1;
      return VMAX;
    end
    return longint'(m);
  endfunction

  function automatic void lorenz_rates(input longint x, y, z, output longint fx, fy, fz);
    fx = mul_sat(k_a, sub_sat(y, x));
    fy = sub_sat(mul_sat(x, sub_sat(k_r, z)), y);
    fz = sub_sat(mul_sat(x, y), mul_sat(z, k_c));
  endfunction

  function automatic lorenz_sample_t heun_step();
    lorenz_sample_t s;
    longint fx, fy, fz, gx, gy, gz, px, py, pz, dt, dt2;
    s.x = pt_x;
    s.y = pt_y;
    s.z = pt_z;
    clip_seen = 1'b0;
    dt = longint'(k_dt);
    dt2 = dt >>> 1;
    lorenz_rates(pt_x, pt_y, pt_z, fx, fy, fz);
    px = add_sat(pt_x, mul_sat(dt, fx));
    py = add_sat(pt_y, mul_sat(dt, fy));
    pz = add_sat(pt_z, mul_sat(dt, fz));
    lorenz_rates(px, py, pz, gx, gy, gz);
    pt_x = 32'(add_sat(pt_x, mul_sat(dt2, add_sat(fx, gx))));
    pt_y = 32'(add_sat(pt_y, mul_sat(dt2, add_sat(fy, gy))));
    pt_z = 32'(add_sat(pt_z, mul_sat(dt2, add_sat(fz, gz))));
    s.sat = clip_seen;
    return s;
  endfunction

  function automatic int gap_len(inout bit calm);
    int r;
    if ($urandom_range(0, 49) == 0) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // value in [-span, span]
  function automatic int near_q(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic push_item(logic [1:0] op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    lorenz_cmd_t c;
    c.op = op;
    c.x = x;
    c.y = y;
    c.z = z;
    cmd_queue.push_back(c);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      n_errors++;
    end
  endtask

  task automatic write_reg(logic [lhs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      lhs_pkg::CFG_COEF_A:  k_a = data;
      lhs_pkg::CFG_COEF_R:  k_r = data;
      lhs_pkg::CFG_COEF_C:  k_c = data;
      lhs_pkg::CFG_STEP_DT: k_dt = data[lhs_pkg::DT_W-1:0];
      lhs_pkg::CFG_INIT_X:  seed_x = data;
      lhs_pkg::CFG_INIT_Y:  seed_y = data;
      lhs_pkg::CFG_INIT_Z:  seed_z = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(logic [31:0] a, r, c, dt, ix, iy, iz);
    write_reg(lhs_pkg::CFG_COEF_A, a);
    write_reg(lhs_pkg::CFG_COEF_R, r);
    write_reg(lhs_pkg::CFG_COEF_C, c);
    write_reg(lhs_pkg::CFG_STEP_DT, dt);
    write_reg(lhs_pkg::CFG_INIT_X, ix);
    write_reg(lhs_pkg::CFG_INIT_Y, iy);
    write_reg(lhs_pkg::CFG_INIT_Z, iz);
    n_settings++;
  endtask

  // sender stays quiet until every result is back and the block has settled
  task automatic drain();
    while (cmd_queue.size() != 0 || in_valid_i || sample_queue.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // mostly load or reset followed by a run of steps; some wild loads and noise
  task automatic queue_random(int n);
    int made, kind, run;
    logic [1:0] op;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        if ($urandom_range(0, 3) == 0)
          push_item(lhs_pkg::IN_RESET, $urandom, $urandom, $urandom);
        else
          push_item(lhs_pkg::IN_LOAD, near_q(40 << 24), near_q(40 << 24),
                    near_q(40 << 24));
        run = $urandom_range(1, 12);
        repeat (run) push_item(lhs_pkg::IN_STEP, $urandom, $urandom, $urandom);
        made += run + 1;
      end else if (kind < 85) begin
        push_item(lhs_pkg::IN_LOAD, $urandom, $urandom, $urandom);
        run = $urandom_range(1, 4);
        repeat (run) push_item(lhs_pkg::IN_STEP, $urandom, $urandom, $urandom);
        made += run + 1;
      end else begin
        op = 2'($urandom_range(0, 3));
        push_item(op, $urandom, $urandom, $urandom);
        if (op != IN_UNUSED) made++;
      end
    end
  endtask

  // input driver and predictor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        case (cmd_i)
          lhs_pkg::IN_STEP: begin
            drv_sample = heun_step();
            sample_queue.push_back(drv_sample);
            n_steps++;
            if (drv_sample.sat) n_clipped++;
          end
          lhs_pkg::IN_LOAD: begin
            pt_x = x_in_i;
            pt_y = y_in_i;
            pt_z = z_in_i;
            n_loads++;
          end
          lhs_pkg::IN_RESET: begin
            pt_x = seed_x;
            pt_y = seed_y;
            pt_z = seed_z;
            n_resets++;
          end
          default: n_ignored++;
        endcase
      end
      if (!in_valid_i || !in_stall_o) begin
        if (idle_left != 0) begin
          idle_left--;
          in_valid_i <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          drv_item = cmd_queue.pop_front();
          in_valid_i <= 1'b1;
          cmd_i  <= drv_item.op;
          x_in_i <= drv_item.x;
          y_in_i <= drv_item.y;
          z_in_i <= drv_item.z;
          idle_left = gap_len(calm_in);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (sample_queue.size() == 0) begin
          $display("%0t: result transfer with none expected, actual %h %h %h %b", $time,
                   x_out_o, y_out_o, z_out_o, saturated_o);
          n_errors++;
        end else begin
          mon_sample = sample_queue.pop_front();
          compare_field("x_out", mon_sample.x, x_out_o);
          compare_field("y_out", mon_sample.y, y_out_o);
          compare_field("z_out", mon_sample.z, z_out_o);
          compare_field("saturated", 32'(mon_sample.sat), 32'(saturated_o));
          n_checked++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = gap_len(calm_out);
        out_stall_i <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: edges of the fields, every command, ignored code
    push_item(lhs_pkg::IN_STEP, 32'h0, 32'h0, 32'h0);
    push_item(lhs_pkg::IN_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(lhs_pkg::IN_STEP, 32'h0, 32'h0, 32'h0);
    push_item(lhs_pkg::IN_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_item(lhs_pkg::IN_STEP, 32'h0, 32'h0, 32'h0);
    push_item(lhs_pkg::IN_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_item(lhs_pkg::IN_STEP, 32'h0, 32'h0, 32'h0);
    push_item(lhs_pkg::IN_LOAD, 32'h0, 32'h0, 32'h0);
    push_item(lhs_pkg::IN_STEP, 32'h0, 32'h0, 32'h0);
    push_item(lhs_pkg::IN_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    push_item(lhs_pkg::IN_STEP, 32'h0, 32'h0, 32'h0);
    push_item(IN_UNUSED, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF);
    push_item(lhs_pkg::IN_STEP, 32'h0, 32'h0, 32'h0);
    push_item(lhs_pkg::IN_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(lhs_pkg::IN_STEP, 32'h0, 32'h0, 32'h0);
    push_item(lhs_pkg::IN_LOAD, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
    push_item(lhs_pkg::IN_STEP, 32'h0, 32'h0, 32'h0);
    push_item(lhs_pkg::IN_STEP, 32'h0, 32'h0, 32'h0);
    push_item(lhs_pkg::IN_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(lhs_pkg::IN_STEP, 32'h0, 32'h0, 32'h0);
    push_item(IN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(lhs_pkg::IN_RESET, 32'h0, 32'h0, 32'h0);
    push_item(lhs_pkg::IN_STEP, 32'h0, 32'h0, 32'h0);
    drain();

    apply_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_item(lhs_pkg::IN_RESET, 32'h0, 32'h0, 32'h0);
    queue_random(40);
    drain();

    apply_setting(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_item(lhs_pkg::IN_RESET, 32'h0, 32'h0, 32'h0);
    queue_random(40);
    drain();

    apply_setting(lhs_pkg::RST_COEF_A, lhs_pkg::RST_COEF_R, lhs_pkg::RST_COEF_C,
                  32'(lhs_pkg::RST_DT), lhs_pkg::RST_INIT, lhs_pkg::RST_INIT,
                  lhs_pkg::RST_INIT);
    queue_random(120);
    drain();

    for (int k = 0; k < 3; k++) begin
      apply_setting(near_q(16 << 24), near_q(48 << 24), near_q(8 << 24),
                    (k == 0) ? 32'h0100_0000 : 32'($urandom_range(0, 1 << 24)),
                    near_q(40 << 24), near_q(40 << 24), near_q(40 << 24));
      queue_random(80);
      drain();
    end

    apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    queue_random(40);
    drain();

    $display("Run covered %0d steps (%0d saturating), %0d loads, %0d resets, %0d ignored",
             n_steps, n_clipped, n_loads, n_resets, n_ignored);
    $display("over %0d register settings besides reset; %0d results checked, %0d errors",
             n_settings, n_checked, n_errors);
    if (n_errors == 0 && sample_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/lhs_pkg.sv
design/lhs_ctrl.sv
design/lhs_datapath.sv
design/lorenz_heun_stepper_unit.sv
design/lhs_checker.sv
test/lorenz_heun_stepper_unit_tb.sv
